@@ hw/rtl/hts_pkg.sv @@
// ----------------------------------------------------------------------------
// hts_pkg
// Shared types, constants and hash functions of the hash threshold sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hts_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HASH_W = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // register index, taken from paddr[ADDR_W-1:2]
  localparam logic [ADDR_W-3:0] REG_KEEP_THRESHOLD = 1'b0;

  typedef logic [HASH_W-1:0] hash_t;

  // absorbed hash of a finished key, handed to the mixing stage
  typedef struct packed {
    logic  valid;
    hash_t hash;
  } hts_key_t;

  // one-at-a-time per-byte update
  function automatic hash_t hts_absorb(input hash_t h, input logic [BYTE_W-1:0] b);
    hash_t t;
    t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  // final avalanche
  function automatic hash_t hts_finish(input hash_t h);
    hash_t t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hash_threshold_sampler.sv @@
// ----------------------------------------------------------------------------
// hash_threshold_sampler
// Keeps or drops keys by their one-at-a-time hash against a threshold.
// ----------------------------------------------------------------------------
// Key bytes stream in one word per cycle while s_tready is high, tlast on the
// final byte of a key. Each byte is folded into a running 32-bit hash; on the
// final byte the hash is mixed and compared with keep_threshold (APB register
// at address 0), and one result word leaves with the final hash in tdata and
// the keep flag in tuser. Bytes without tlast give no output. The block takes
// one byte every cycle unless a final byte waits on a stalled output; a key's
// result passes through the input, absorbed-hash and output registers. The
// running hash is the only loop. Write the threshold only while no key is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_threshold_sampler
  import hts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,   // [7:0] key_byte
  input  wire logic              s_tlast,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [HASH_W-1:0]      m_tdata,   // [31:0] hash_value
  output logic [0:0]             m_tuser,   // [0] keep
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  hash_t    keep_threshold;
  hts_key_t key;
  logic     key_ready;

  hts_cfg u_cfg (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .keep_threshold (keep_threshold)
  );

  hts_absorb u_absorb (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .key       (key),
    .key_ready (key_ready)
  );

  hts_finish u_finish (
    .clk            (clk),
    .rst            (rst),
    .key            (key),
    .key_ready      (key_ready),
    .keep_threshold (keep_threshold),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hts_cfg.sv @@
// ----------------------------------------------------------------------------
// hts_cfg
// APB register file holding the keep threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_cfg
  import hts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output hash_t                  keep_threshold
);

  logic [ADDR_W-3:0] reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_threshold <= '0;
    end else if (wr_en && (reg_idx == REG_KEEP_THRESHOLD)) begin
      keep_threshold <= pwdata[HASH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_KEEP_THRESHOLD) begin
      prdata = keep_threshold;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hts_absorb.sv @@
// ----------------------------------------------------------------------------
// hts_absorb
// Input register and running hash; hands the absorbed hash of each
// finished key to the mixing stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_absorb
  import hts_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [BYTE_W-1:0] s_tdata,
  input  wire logic              s_tlast,
  output hts_key_t               key,
  input  wire logic              key_ready
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  hash_t             running_hash;
  hash_t             absorbed;
  logic              key_load;
  logic              step;
  logic              key_valid;
  hash_t             key_hash;

  assign key      = '{valid: key_valid, hash: key_hash};
  assign absorbed = hts_absorb(running_hash, in_byte);
  assign key_load = !key_valid || key_ready;
  // a non-final byte never waits on the result side
  assign step     = in_valid && (!in_last || key_load);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      running_hash <= '0;
      key_valid    <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (step) begin
        running_hash <= in_last ? '0 : absorbed;
      end
      if (key_load) begin
        key_valid <= step && in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
    if (key_load && step && in_last) begin
      key_hash <= absorbed;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hts_finish.sv @@
// ----------------------------------------------------------------------------
// hts_finish
// Final mixing, threshold compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hts_finish
  import hts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire hts_key_t key,
  output logic          key_ready,
  input  wire hash_t    keep_threshold,
  output logic          m_tvalid,
  input  wire logic     m_tready,
  output hash_t         m_tdata,
  output logic [0:0]    m_tuser
);

  hash_t mixed;

  assign mixed     = hts_finish(key.hash);
  assign key_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (key_ready) begin
      m_tvalid <= key.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_ready && key.valid) begin
      m_tdata    <= mixed;
      m_tuser[0] <= (mixed >= keep_threshold);
    end
  end

endmodule

`default_nettype wire
